>>> rtl/wmin2d_pkg.sv
package wmin2d_pkg;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_WINDOW_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_WINDOW_HEIGHT = 2'd3;

   localparam logic [10:0] IMAGE_WIDTH_RESET   = 11'd1024;
   localparam logic [15:0] IMAGE_HEIGHT_RESET  = 16'd1024;
   localparam logic [6:0]  WINDOW_WIDTH_RESET  = 7'd3;
   localparam logic [4:0]  WINDOW_HEIGHT_RESET = 5'd3;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic col_read;
      logic col_cmp;
      logic front_read;
      logic front_cmp;
      logic back_read;
      logic back_cmp;
      logic push;
      logic head_read;
      logic emit;
      logic advance;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic window;
      logic multi_row;
      logic col_more;
      logic deque_empty;
      logic back_less;
      logic emit_due;
      logic out_free;
   } status_type;

endpackage

>>> rtl/window_minimum_2d_filter_top.sv
// two-dimensional sliding-window minimum over a raster stream of signed pixels
// req channel: one pixel per beat (req_valid/req_ready), raster order
// rsp channel: one beat per completed window: minimum, row end and frame end
// csr port: csr_write with csr_index selects image width, image height,
//   window width or window height; a write restarts the frame at row 0
// each pixel is written to the line store; while its row is above the first
//   full window that is all; otherwise its column minimum is read through the
//   single read port of the line store, the deque front is checked, the back
//   scan drops every entry not less than the column minimum until it ends on a
//   smaller entry or an empty deque, the push follows and,
//   when a result is due, the deque head is read into the rsp register
// result appears on rsp the cycle after its last pixel step
// reset: registers return to 1024x1024 image and 3x3 window, frame restarts,
//   rsp_valid drops; line store contents are not cleared
// a stalled rsp beat holds; the next pixel is still accepted, and a pixel
//   whose result is due waits only until the rsp register is free
module window_minimum_2d_filter_top
   import wmin2d_pkg::*;
#(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_WIN_ROWS = 16,
   parameter int MAX_WIN_COLS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pixel,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_window_min,
   output logic               rsp_row_end,
   output logic               rsp_frame_end
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: walks one pixel through column, deque and output steps
   wmin2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, line store, deque memory, rsp register
   wmin2d_dp #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_WIN_ROWS (MAX_WIN_ROWS),
      .MAX_WIN_COLS (MAX_WIN_COLS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_window_min (rsp_window_min),
      .rsp_row_end    (rsp_row_end),
      .rsp_frame_end  (rsp_frame_end),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

>>> rtl/wmin2d_ram.sv
module wmin2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/wmin2d_ctrl.sv
module wmin2d_ctrl
   import wmin2d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_COL_RD    = 4'd1;
   localparam logic [3:0] S_COL_CMP   = 4'd2;
   localparam logic [3:0] S_FRONT_RD  = 4'd3;
   localparam logic [3:0] S_FRONT_CMP = 4'd4;
   localparam logic [3:0] S_BACK_RD   = 4'd5;
   localparam logic [3:0] S_BACK_CMP  = 4'd6;
   localparam logic [3:0] S_PUSH      = 4'd7;
   localparam logic [3:0] S_HEAD_RD   = 4'd8;
   localparam logic [3:0] S_EMIT      = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               if (!status.window) begin
                  cmd.advance = 1'b1;
               end else if (status.multi_row) begin
                  state_in = S_COL_RD;
               end else begin
                  state_in = S_FRONT_RD;
               end
            end
         end
         S_COL_RD: begin
            cmd.col_read = 1'b1;
            state_in     = S_COL_CMP;
         end
         S_COL_CMP: begin
            cmd.col_cmp = 1'b1;
            state_in    = status.col_more ? S_COL_RD : S_FRONT_RD;
         end
         S_FRONT_RD: begin
            cmd.front_read = 1'b1;
            state_in       = S_FRONT_CMP;
         end
         S_FRONT_CMP: begin
            cmd.front_cmp = 1'b1;
            state_in      = S_BACK_RD;
         end
         S_BACK_RD: begin
            if (status.deque_empty) begin
               state_in = S_PUSH;
            end else begin
               cmd.back_read = 1'b1;
               state_in      = S_BACK_CMP;
            end
         end
         S_BACK_CMP: begin
            cmd.back_cmp = 1'b1;
            state_in     = status.back_less ? S_PUSH : S_BACK_RD;
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            if (status.emit_due) begin
               state_in = S_HEAD_RD;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_HEAD_RD: begin
            cmd.head_read = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.advance = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded while output register is occupied");
   a_no_window_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && !status.window) |=> (state_ff == S_IDLE))
      else $error("pixel without window did not return to idle");
   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff <= S_EMIT)
      else $error("controller state out of range");
`endif

endmodule

>>> rtl/wmin2d_dp.sv
module wmin2d_dp
   import wmin2d_pkg::*;
#(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_WIN_ROWS = 16,
   parameter int MAX_WIN_COLS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic signed [31:0] req_pixel,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_window_min,
   output logic               rsp_row_end,
   output logic               rsp_frame_end,
   input  cmd_type            cmd,
   output status_type         status
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int SW = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1;
   localparam int RW = $clog2(MAX_WIN_ROWS + 1);
   localparam int LD = MAX_WIN_ROWS * MAX_WIDTH;
   localparam int LA = $clog2(LD);
   localparam int QW = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1;
   localparam int NW = $clog2(MAX_WIN_COLS + 1);
   localparam int DW = 32 + CW;

   // configuration
   logic [10:0] img_w_ff;
   logic [15:0] img_h_ff;
   logic [6:0]  win_w_ff;
   logic [4:0]  win_h_ff;

   logic [CW:0]   w_eff;
   logic [15:0]   h_eff;
   logic [NW-1:0] ww_eff;
   logic [RW-1:0] wh_eff;

   always_comb begin
      if (img_w_ff == 11'd0) begin
         w_eff = (CW+1)'(1);
      end else if (32'(img_w_ff) > 32'(MAX_WIDTH)) begin
         w_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         w_eff = (CW+1)'(img_w_ff);
      end
      h_eff = (img_h_ff == 16'd0) ? 16'd1 : img_h_ff;
      if (win_w_ff == 7'd0) begin
         ww_eff = NW'(1);
      end else if (32'(win_w_ff) > 32'(MAX_WIN_COLS)) begin
         ww_eff = NW'(MAX_WIN_COLS);
      end else begin
         ww_eff = NW'(win_w_ff);
      end
      if (win_h_ff == 5'd0) begin
         wh_eff = RW'(1);
      end else if (32'(win_h_ff) > 32'(MAX_WIN_ROWS)) begin
         wh_eff = RW'(MAX_WIN_ROWS);
      end else begin
         wh_eff = RW'(win_h_ff);
      end
   end

   // position and per-pixel work registers
   logic [CW-1:0]      col_ff, col_in;
   logic [15:0]        row_ff, row_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [SW-1:0]      rd_slot_ff, rd_slot_in;
   logic [RW-1:0]      krem_ff, krem_in;
   logic signed [31:0] colmin_ff, colmin_in;
   logic [QW-1:0]      head_ff, head_in;
   logic [NW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_min_ff, rsp_min_in;
   logic               rsp_re_ff, rsp_re_in;
   logic               rsp_fe_ff, rsp_fe_in;

   function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
      return (s == '0) ? SW'(MAX_WIN_ROWS - 1) : s - SW'(1);
   endfunction

   function automatic logic [LA-1:0] ls_addr(input logic [SW-1:0] s,
                                             input logic [CW-1:0] cc);
      return LA'(32'(s) * MAX_WIDTH + 32'(cc));
   endfunction

   // deque ring index arithmetic, head + count [- 1] wrapped once
   logic [QW+1:0] push_sum, back_sum;
   logic [QW-1:0] push_idx, back_idx, head_next;

   always_comb begin
      push_sum  = (QW+2)'(head_ff) + (QW+2)'(count_ff);
      back_sum  = push_sum - (QW+2)'(1);
      push_idx  = (push_sum >= (QW+2)'(MAX_WIN_COLS)) ?
                  QW'(push_sum - (QW+2)'(MAX_WIN_COLS)) : QW'(push_sum);
      back_idx  = (back_sum >= (QW+2)'(MAX_WIN_COLS)) ?
                  QW'(back_sum - (QW+2)'(MAX_WIN_COLS)) : QW'(back_sum);
      head_next = ((QW+1)'(head_ff) + (QW+1)'(1) >= (QW+1)'(MAX_WIN_COLS)) ?
                  '0 : head_ff + QW'(1);
   end

   // memories
   logic [31:0]   ls_rd_data;
   logic          dq_wr_en, dq_rd_en;
   logic [QW-1:0] dq_rd_addr;
   logic [DW-1:0] dq_rd_data;

   wmin2d_ram #(.WIDTH(32), .DEPTH(LD)) u_line_store (
      .clock   (clock),
      .wr_en   (cmd.start),
      .wr_addr (ls_addr(slot_ff, col_ff)),
      .wr_data (req_pixel),
      .rd_en   (cmd.col_read),
      .rd_addr (ls_addr(rd_slot_ff, col_ff)),
      .rd_data (ls_rd_data)
   );

   assign dq_wr_en   = cmd.push && (32'(count_ff) < MAX_WIN_COLS);
   assign dq_rd_en   = cmd.front_read || cmd.back_read || cmd.head_read;
   assign dq_rd_addr = cmd.back_read ? back_idx : head_ff;

   wmin2d_ram #(.WIDTH(DW), .DEPTH(MAX_WIN_COLS)) u_deque (
      .clock   (clock),
      .wr_en   (dq_wr_en),
      .wr_addr (push_idx),
      .wr_data ({colmin_ff, col_ff}),
      .rd_en   (dq_rd_en),
      .rd_addr (dq_rd_addr),
      .rd_data (dq_rd_data)
   );

   logic signed [31:0] dq_value;
   logic [CW-1:0]      dq_col;
   logic               front_hit;
   logic               last_col;

   assign dq_value  = $signed(dq_rd_data[DW-1:CW]);
   assign dq_col    = dq_rd_data[CW-1:0];
   assign front_hit = (count_ff != '0) && (16'(col_ff) >= 16'(ww_eff)) &&
                      (dq_col == CW'(16'(col_ff) - 16'(ww_eff)));
   assign last_col  = (16'(col_ff) == 16'(w_eff) - 16'd1);

   assign status.window      = (17'(row_ff) + 17'd1) >= 17'(wh_eff);
   assign status.multi_row   = (wh_eff > RW'(1));
   assign status.col_more    = (krem_ff != '0);
   assign status.deque_empty = (count_ff == '0);
   assign status.back_less   = dq_value < colmin_ff;
   assign status.emit_due    = (16'(col_ff) + 16'd1) >= 16'(ww_eff);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      slot_in      = slot_ff;
      rd_slot_in   = rd_slot_ff;
      krem_in      = krem_ff;
      colmin_in    = colmin_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_min_in   = rsp_min_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_fe_in    = rsp_fe_ff;

      if (cmd.start) begin
         colmin_in  = req_pixel;
         rd_slot_in = slot_dec(slot_ff);
         krem_in    = wh_eff - RW'(1);
         if (col_ff == '0) begin
            head_in  = '0;
            count_in = '0;
         end
      end
      if (cmd.col_read) begin
         rd_slot_in = slot_dec(rd_slot_ff);
         krem_in    = krem_ff - RW'(1);
      end
      if (cmd.col_cmp && ($signed(ls_rd_data) < colmin_ff)) begin
         colmin_in = $signed(ls_rd_data);
      end
      if (cmd.front_cmp && front_hit) begin
         head_in  = head_next;
         count_in = count_ff - NW'(1);
      end
      if (cmd.back_cmp && !status.back_less) begin
         count_in = count_ff - NW'(1);
      end
      if (dq_wr_en) begin
         count_in = count_ff + NW'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_min_in   = dq_value;
         rsp_re_in    = last_col;
         rsp_fe_in    = last_col && (row_ff == h_eff - 16'd1);
      end
      if (cmd.advance) begin
         if ((16'(col_ff) + 16'd1) >= 16'(w_eff)) begin
            col_in = '0;
            if ((17'(row_ff) + 17'd1) >= 17'(h_eff)) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + 16'd1;
               slot_in = (32'(slot_ff) + 1 >= MAX_WIN_ROWS) ? '0 : slot_ff + SW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      // register write restarts the frame
      if (csr_write) begin
         col_in   = '0;
         row_in   = '0;
         slot_in  = '0;
         head_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff     <= IMAGE_WIDTH_RESET;
         img_h_ff     <= IMAGE_HEIGHT_RESET;
         win_w_ff     <= WINDOW_WIDTH_RESET;
         win_h_ff     <= WINDOW_HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   img_w_ff <= csr_wdata[10:0];
               CSR_IMAGE_HEIGHT:  img_h_ff <= csr_wdata;
               CSR_WINDOW_WIDTH:  win_w_ff <= csr_wdata[6:0];
               CSR_WINDOW_HEIGHT: win_h_ff <= csr_wdata[4:0];
               default: begin
               end
            endcase
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         slot_ff      <= slot_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= rd_slot_in;
      krem_ff    <= krem_in;
      colmin_ff  <= colmin_in;
      rsp_min_ff <= rsp_min_in;
      rsp_re_ff  <= rsp_re_in;
      rsp_fe_ff  <= rsp_fe_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_min = rsp_min_ff;
   assign rsp_row_end    = rsp_re_ff;
   assign rsp_frame_end  = rsp_fe_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_WIN_COLS)
      else $error("deque holds more entries than its depth");
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      32'(slot_ff) < MAX_WIN_ROWS)
      else $error("line store row slot out of range");
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && rsp_fe_in) |-> rsp_re_in)
      else $error("frame end without row end");
`endif

endmodule

>>> test/wmin2d_checker.sv
module wmin2d_checker
   import wmin2d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_pixel,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_window_min,
   input  logic               rsp_row_end,
   input  logic               rsp_frame_end,
   output int                 pending,
   output int                 fail_count
);

   typedef struct {
      logic signed [31:0] minimum;
      logic               row_end;
      logic               frame_end;
   } window_result_type;

   // expected results in order, ring of 64 entries
   window_result_type  minima_due [64];
   int                 due_wr, due_rd;
   logic signed [31:0] rows_kept [16*1024];
   logic signed [31:0] dq_val [64];
   int                 dq_col [64];
   int                 dq_head, dq_cnt, row_at, col_at;
   logic [10:0]        img_w;
   logic [15:0]        img_h;
   logic [6:0]         win_w;
   logic [4:0]         win_h;

   function automatic int clamp(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_frame();
      row_at  = 0;
      col_at  = 0;
      dq_head = 0;
      dq_cnt  = 0;
   endfunction

   function automatic void track_minimum(input logic signed [31:0] p);
      int w, h, ww, wh, r, c, k, back, slot;
      logic signed [31:0] colmin;
      window_result_type res;
      w  = clamp(img_w, 1024);
      h  = clamp(img_h, 65535);
      ww = clamp(win_w, 64);
      wh = clamp(win_h, 16);
      r  = row_at;
      c  = col_at;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      rows_kept[(r % 16) * 1024 + c] = p;
      if (c == 0) begin
         dq_head = 0;
         dq_cnt  = 0;
      end
      if (r + 1 >= wh) begin
         colmin = p;
         for (k = 1; k < wh; k++)
            if (rows_kept[((r - k) % 16) * 1024 + c] < colmin)
               colmin = rows_kept[((r - k) % 16) * 1024 + c];
         if (dq_cnt > 0 && c >= ww && dq_col[dq_head] == c - ww) begin
            dq_head = (dq_head + 1) % 64;
            dq_cnt--;
         end
         while (dq_cnt > 0) begin
            back = (dq_head + dq_cnt - 1) % 64;
            if (dq_val[back] < colmin) break;
            dq_cnt--;
         end
         if (dq_cnt < 64) begin
            slot = (dq_head + dq_cnt) % 64;
            dq_val[slot] = colmin;
            dq_col[slot] = c;
            dq_cnt++;
         end
         if (c + 1 >= ww) begin
            res.minimum   = dq_val[dq_head];
            res.row_end   = (c == w - 1);
            res.frame_end = (c == w - 1) && (r == h - 1);
            minima_due[due_wr % 64] = res;
            due_wr++;
         end
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_at = c;
      row_at = r;
   endfunction

   assign pending = due_wr - due_rd;

   always @(posedge clock) begin
      window_result_type exp_res;
      if (reset) begin
         img_w = IMAGE_WIDTH_RESET;
         img_h = IMAGE_HEIGHT_RESET;
         win_w = WINDOW_WIDTH_RESET;
         win_h = WINDOW_HEIGHT_RESET;
         restart_frame();
         due_wr     = 0;
         due_rd     = 0;
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_wr == due_rd) begin
               $error("unexpected rsp beat: window_min %0d", rsp_window_min);
               fail_count++;
            end else begin
               exp_res = minima_due[due_rd % 64];
               due_rd++;
               if (rsp_window_min !== exp_res.minimum) begin
                  $error("window_min expected %0d actual %0d", exp_res.minimum,
                         rsp_window_min);
                  fail_count++;
               end
               if (rsp_row_end !== exp_res.row_end) begin
                  $error("row_end expected %0d actual %0d", exp_res.row_end,
                         rsp_row_end);
                  fail_count++;
               end
               if (rsp_frame_end !== exp_res.frame_end) begin
                  $error("frame_end expected %0d actual %0d", exp_res.frame_end,
                         rsp_frame_end);
                  fail_count++;
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   img_w = csr_wdata[10:0];
               CSR_IMAGE_HEIGHT:  img_h = csr_wdata;
               CSR_WINDOW_WIDTH:  win_w = csr_wdata[6:0];
               CSR_WINDOW_HEIGHT: win_h = csr_wdata[4:0];
               default: begin
               end
            endcase
            restart_frame();
         end
         if (req_valid && req_ready)
            track_minimum(req_pixel);
      end
   end

endmodule

>>> test/tb_top.sv
module tb_top;
   import wmin2d_pkg::*;

   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT   = 3000000;

   logic               clock;
   logic               reset;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_pixel;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_window_min;
   logic               rsp_row_end;
   logic               rsp_frame_end;
   int                 pending;
   int                 fail_count;
   int                 cycles;
   bit                 no_idle;        // phase without gaps or stalls

   window_minimum_2d_filter_top i_dut (
      .clock, .reset, .csr_write, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_pixel,
      .rsp_valid, .rsp_ready, .rsp_window_min, .rsp_row_end, .rsp_frame_end
   );

   wmin2d_checker i_checker (
      .clock, .reset, .csr_write, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_pixel,
      .rsp_valid, .rsp_ready, .rsp_window_min, .rsp_row_end, .rsp_frame_end,
      .pending, .fail_count
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // rsp side: random stall before every beat, none in quiet phases
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // one pixel beat; valid stays up when the next beat follows at once
   task automatic send_pixel(input logic signed [31:0] p);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait for the block to drain, then write all four registers back to back
   task automatic set_frame(input int w, input int h, input int ww, input int wh);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= 16'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= 16'(h);
      @(posedge clock);
      csr_index <= CSR_WINDOW_WIDTH;
      csr_wdata <= 16'(ww);
      @(posedge clock);
      csr_index <= CSR_WINDOW_HEIGHT;
      csr_wdata <= 16'(wh);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // mostly a narrow range so ties and repeats show up, sometimes full range
   function automatic logic signed [31:0] rand_pixel();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $signed($urandom_range(0, 8)) - 4;
         default: return $signed($urandom_range(0, 200)) - 100;
      endcase
   endfunction

   initial begin
      logic signed [31:0] directed_px [24];
      int w, h, ww, wh, n, sent;
      directed_px = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 5, 5, 5, 5,
                      32'sh7fff_ffff, 32'sh8000_0000, 3, 3, 7, 2, 2, 7,
                      -1, 32'sh8000_0001, 32'sh7fff_fffe, 0, 4, 4, 9, -9};
      no_idle   = 1'b0;
      reset     = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_pixel = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset configuration, a few pixels of the 1024-wide image
      for (int i = 0; i < 8; i++) send_pixel(directed_px[i]);

      // directed: extremes and ties on a 4x3 image, 2x2 window, two frames
      set_frame(4, 3, 2, 2);
      foreach (directed_px[i]) send_pixel(directed_px[i]);

      // zeros are taken as one: every pixel gives its own result
      set_frame(0, 0, 0, 0);
      for (int i = 0; i < 6; i++) send_pixel(rand_pixel());

      // all bits set: width and windows saturate, window too tall for rows
      set_frame(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      for (int i = 0; i < 40; i++) send_pixel(rand_pixel());

      // window wider than the image: no results at all
      set_frame(5, 4, 6, 2);
      for (int i = 0; i < 20; i++) send_pixel(rand_pixel());

      // widest window: 64 columns over a short image
      no_idle = 1'b1;
      set_frame(66, 4, 64, 4);
      for (int i = 0; i < 66 * 4; i++) send_pixel(rand_pixel());
      no_idle = 1'b0;

      // tallest window: 16 rows over a narrow image
      set_frame(4, 16, 2, 16);
      for (int i = 0; i < 4 * 16; i++) send_pixel(rand_pixel());

      // random small frames, partial frames included
      sent = 0;
      while (sent < 330) begin
         w  = $urandom_range(0, 12);
         h  = $urandom_range(1, 8);
         ww = $urandom_range(0, (w < 1 ? 1 : w) + 1);
         wh = $urandom_range(0, h + 1);
         no_idle = ($urandom_range(0, 3) == 0);
         set_frame(w, h, ww, wh);
         n = $urandom_range(1, 2 * (w < 1 ? 1 : w) * h + 12);
         for (int i = 0; i < n; i++) send_pixel(rand_pixel());
         sent += n;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
